// ----- rtl/line_buffered_2d_convolution_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the line-buffered 2-D convolution block.
// Checks are clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINE_BUFFERED_2D_CONVOLUTION_TOP_ASSERT_SVH
`define LINE_BUFFERED_2D_CONVOLUTION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define LBC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define LBC_ASSERT(lbl, prop, msg)
`define LBC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/lbc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbc_pkg
// Shared constants, codes and types of the line-buffered 2-D convolution.
// ---------------------------------------------------------------------------
package lbc_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int K_MAX_DEF      = 7;

	localparam int PIX_W   = 16;
	localparam int CFG_W   = 11;
	localparam int KS_W    = 3;
	localparam int ROW_O_W = 10;
	localparam int COL_O_W = 10;
	localparam int CIDX_W  = 6;

	localparam logic [1:0] MODE_COEF  = 2'd0;
	localparam logic [1:0] MODE_PIXEL = 2'd1;
	localparam logic [1:0] MODE_DRAIN = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_KSIZE  = 2'd2;
	localparam logic [1:0] CFG_BORDER = 2'd3;

	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_PIX  = 2'd1;
	localparam logic [1:0] SRC_MEM  = 2'd2;

	typedef struct packed {
		logic vld;
		logic use_tap;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

// ----- rtl/lbc_line_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbc_line_mem
// Line store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lbc_line_mem #(
	parameter int DEPTH = 6144,
	parameter int AW    = 13
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [lbc_pkg::PIX_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [lbc_pkg::PIX_W-1:0] rdata
);
	import lbc_pkg::*;

	logic [PIX_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/lbc_coef_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbc_coef_mem
// Coefficient store with per-entry valid bits; unwritten entries read zero.
// ---------------------------------------------------------------------------
module lbc_coef_mem #(
	parameter int DEPTH = 49,
	parameter int AW    = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [lbc_pkg::PIX_W-1:0] wdata,
	input  logic [AW-1:0]                    raddr,
	output logic signed [lbc_pkg::PIX_W-1:0] rdata
);
	import lbc_pkg::*;

	logic signed [PIX_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]        vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= vld_q[raddr] ? mem_q[raddr] : '0;
	end

endmodule

// ----- rtl/lbc_mac.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbc_mac
// Multiply-accumulate pipeline with rounding and saturation to 16 bits.
// ---------------------------------------------------------------------------
module lbc_mac #(
	parameter int K_MAX = 7
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lbc_pkg::mac_ctl_t                ctl_s1,
	input  logic signed [lbc_pkg::PIX_W-1:0] coef_s1,
	input  logic signed [lbc_pkg::PIX_W-1:0] tap_s1,
	output logic                             res_vld,
	output logic signed [lbc_pkg::PIX_W-1:0] res
);
	import lbc_pkg::*;

	localparam int ACC_W = 2 * PIX_W + $clog2(K_MAX * K_MAX) + 1;

	mac_ctl_t                ctl_s2;
	logic signed [2*PIX_W-1:0] prod_s2;
	logic                    done_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] quo;
	logic signed [PIX_W-1:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			done_s3 <= 1'b0;
			res_vld <= 1'b0;
		end else begin
			ctl_s2  <= ctl_s1;
			done_s3 <= ctl_s2.vld & ctl_s2.last;
			res_vld <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ctl_s1.use_tap ? coef_s1 * tap_s1 : 32'sd0;
		if (ctl_s2.vld) begin
			acc_q <= ctl_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
		res <= sat;
	end

	always_comb begin
		rnd = acc_q + ACC_W'(16384);
		quo = rnd >>> 15;
		if (quo > ACC_W'(32767)) begin
			sat = 16'sh7FFF;
		end else if (quo < -ACC_W'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = quo[PIX_W-1:0];
		end
	end

endmodule

// ----- rtl/line_buffered_2d_convolution_top.sv -----
`timescale 1ns / 1ps
// A pixel or drain beat passes through the fetch, commit and advance states, and each
// result goes through the single multiply-accumulate unit in turn.
// Throughput: one beat at a time; a row-end beat with up to K/2+1 results takes the longest.
// Coefficient loads and ignored beats are accepted without leaving the idle state.
// Reset clears counters, state, window and coefficient valid bits; the line store
// is not cleared, every entry is written before it is read within a frame.
// ---------------------------------------------------------------------------
// line_buffered_2d_convolution_top
// Streaming K x K image filter over a line store with border handling.
// ---------------------------------------------------------------------------
module line_buffered_2d_convolution_top #(
	parameter int MAX_WIDTH  = lbc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbc_pkg::MAX_HEIGHT_DEF,
	parameter int K_MAX      = lbc_pkg::K_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [lbc_pkg::CIDX_W-1:0]        coefficient_index,
	input  logic signed [lbc_pkg::PIX_W-1:0]  coefficient_value,
	input  logic signed [lbc_pkg::PIX_W-1:0]  pixel_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [lbc_pkg::PIX_W-1:0]  pixel_out,
	output logic [lbc_pkg::ROW_O_W-1:0]       out_row,
	output logic [lbc_pkg::COL_O_W-1:0]       out_col,
	output logic                              last_of_run,
	output logic                              status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [lbc_pkg::CFG_W-1:0]         cfg_data
);
	import lbc_pkg::*;

	localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = $clog2(MAX_HEIGHT + K_MAX);
	localparam int SW    = (K_MAX > 2) ? $clog2(K_MAX - 1) : 1;
	localparam int JW    = $clog2(K_MAX);
	localparam int PW    = ((CW > RW) ? CW : RW) + 4;
	localparam int LAW   = SW + CW;
	localparam int LDEP  = (K_MAX - 1) << CW;
	localparam int CDEP  = K_MAX * K_MAX;
	localparam int CAW   = $clog2(CDEP);
	localparam int CIW   = (CAW > CIDX_W) ? CAW : CIDX_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_STATUS  = 4'd1;
	localparam logic [3:0] S_FETCH   = 4'd2;
	localparam logic [3:0] S_VWAIT   = 4'd3;
	localparam logic [3:0] S_COMMIT  = 4'd4;
	localparam logic [3:0] S_MSTART  = 4'd5;
	localparam logic [3:0] S_MISSUE  = 4'd6;
	localparam logic [3:0] S_MWAIT   = 4'd7;
	localparam logic [3:0] S_ADVANCE = 4'd8;

	logic [3:0]        state_q;
	logic [CFG_W-1:0]  wcfg_q, hcfg_q;
	logic [KS_W-1:0]   ks_q;
	logic              border_q;
	logic [RW-1:0]     ri_q;
	logic [CW-1:0]     ci_q;
	logic [SW-1:0]     rslot_q;
	logic signed [PIX_W-1:0] pix_q;
	logic              live_q;
	logic [JW-1:0]     kf_q, ky_q, kx_q;
	logic [CAW-1:0]    fl_q;
	logic signed [PW-1:0] c_q, c1_q;

	logic signed [PIX_W-1:0] win_q [K_MAX][K_MAX];
	logic signed [PIX_W-1:0] vec_q [K_MAX];

	logic              fvld_s1;
	logic [JW-1:0]     fk_s1;
	logic [1:0]        fsrc_s1;
	mac_ctl_t          mac_s1;
	logic signed [PIX_W-1:0] tap_s1;
	logic signed [PIX_W-1:0] coef_s1;

	logic              out_vld_q;
	logic signed [PIX_W-1:0] pix_out_q;
	logic [ROW_O_W-1:0] row_out_q;
	logic [COL_O_W-1:0] col_out_q;
	logic              last_q, stat_q;

	logic signed [PW-1:0] w_eff, h_eff, ksz, half, ri_s, ci_s;
	logic              k_ok, live, in_acc;
	logic signed [PW-1:0] fy, fm, fslot;
	logic [1:0]        fsrc;
	logic              fout;
	logic signed [PW-1:0] mx, mj, c0, c1;
	logic              mout, muse;
	logic              coef_we, line_we, line_re;
	logic [CIW-1:0]    cidx_ext;
	logic [PIX_W-1:0]  line_rd;
	logic              res_vld;
	logic signed [PIX_W-1:0] res;
	logic              cfg_acc;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid;

	always_comb begin
		if (wcfg_q < CFG_W'(3)) begin
			w_eff = PW'(3);
		end else if (PW'(wcfg_q) > PW'(MAX_WIDTH)) begin
			w_eff = PW'(MAX_WIDTH);
		end else begin
			w_eff = PW'(wcfg_q);
		end
		if (hcfg_q < CFG_W'(3)) begin
			h_eff = PW'(3);
		end else if (PW'(hcfg_q) > PW'(MAX_HEIGHT)) begin
			h_eff = PW'(MAX_HEIGHT);
		end else begin
			h_eff = PW'(hcfg_q);
		end
		ksz  = PW'(ks_q);
		half = PW'(ks_q >> 1);
		k_ok = ks_q[0] && (ks_q >= KS_W'(3)) && (PW'(ks_q) <= PW'(K_MAX));
		ri_s = PW'(ri_q);
		ci_s = PW'(ci_q);
		live = ri_s < h_eff;
	end

	// Vertical tap for window row kf: line store, current pixel or padding.
	always_comb begin
		fy   = PW'(ri_s - 2 * half + PW'(kf_q));
		fout = 1'b0;
		if (fy < 0 || fy >= h_eff) begin
			if (!border_q) begin
				fout = 1'b1;
			end
			fy = (fy < 0) ? '0 : PW'(h_eff - 1);
		end
		fm    = ri_s - fy;
		fslot = PW'(rslot_q) - fm;
		if (fslot < 0) begin
			fslot = PW'(fslot + ksz - 1);
		end
		if (fout) begin
			fsrc = SRC_ZERO;
		end else if (fy == ri_s) begin
			fsrc = SRC_PIX;
		end else begin
			fsrc = SRC_MEM;
		end
	end
	assign line_re = (state_q == S_FETCH) && (fsrc == SRC_MEM);
	assign line_we = (state_q == S_COMMIT) && live_q;

	// Horizontal tap for kernel column kx of output column c.
	always_comb begin
		mx   = c_q + PW'(kx_q) - half;
		mout = 1'b0;
		if (mx < 0 || mx > w_eff - 1) begin
			if (!border_q) begin
				mout = 1'b1;
			end
			mx = (mx < 0) ? '0 : PW'(w_eff - 1);
		end
		mj   = PW'(ksz - 1 - (ci_s - mx));
		muse = !mout && (mj >= 0) && (mj < PW'(K_MAX));
	end

	always_comb begin
		if (ci_s < w_eff - 1) begin
			c0 = ci_s - half;
			c1 = (ci_s >= half) ? c0 : PW'(c0 - 1);
		end else begin
			c0 = PW'(w_eff - 1 - half);
			if (c0 < 0) begin
				c0 = '0;
			end
			c1 = PW'(w_eff - 1);
		end
	end

	assign cidx_ext = CIW'(coefficient_index);
	assign coef_we  = in_acc && (mode == MODE_COEF) && (cidx_ext < CIW'(CDEP));

	lbc_coef_mem #(.DEPTH(CDEP), .AW(CAW)) u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (coef_we),
		.waddr  (cidx_ext[CAW-1:0]),
		.wdata  (coefficient_value),
		.raddr  (fl_q),
		.rdata  (coef_s1)
	);

	lbc_line_mem #(.DEPTH(LDEP), .AW(LAW)) u_line (
		.clk   (clk),
		.we    (line_we),
		.waddr ({rslot_q, ci_q}),
		.wdata (pix_q),
		.re    (line_re),
		.raddr ({fslot[SW-1:0], ci_q}),
		.rdata (line_rd)
	);

	lbc_mac #(.K_MAX(K_MAX)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (mac_s1),
		.coef_s1 (coef_s1),
		.tap_s1  (tap_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wcfg_q    <= CFG_W'(1024);
			hcfg_q    <= CFG_W'(1024);
			ks_q      <= KS_W'(3);
			border_q  <= 1'b0;
			ri_q      <= '0;
			ci_q      <= '0;
			rslot_q   <= '0;
			kf_q      <= '0;
			ky_q      <= '0;
			kx_q      <= '0;
			fl_q      <= '0;
			live_q    <= 1'b0;
			fvld_s1   <= 1'b0;
			mac_s1    <= '0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < K_MAX; k++) begin
				for (int j = 0; j < K_MAX; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else begin
			fvld_s1 <= 1'b0;
			mac_s1  <= '0;
			if (out_valid && out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_acc) begin
				unique case (cfg_index)
					CFG_WIDTH:  wcfg_q   <= cfg_data;
					CFG_HEIGHT: hcfg_q   <= cfg_data;
					CFG_KSIZE:  ks_q     <= cfg_data[KS_W-1:0];
					CFG_BORDER: border_q <= cfg_data[0];
					default:    border_q <= border_q;
				endcase
				ri_q    <= '0;
				ci_q    <= '0;
				rslot_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (mode == MODE_PIXEL || mode == MODE_DRAIN)) begin
						if (!k_ok) begin
							state_q <= S_STATUS;
						end else if ((mode == MODE_PIXEL) == live) begin
							live_q  <= live;
							kf_q    <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_STATUS: begin
					if (!out_vld_q) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_FETCH: begin
					fvld_s1 <= 1'b1;
					if (PW'(kf_q) == ksz - 1) begin
						state_q <= S_VWAIT;
					end else begin
						kf_q <= kf_q + 1'b1;
					end
				end
				S_VWAIT: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					for (int k = 0; k < K_MAX; k++) begin
						for (int j = 0; j < K_MAX; j++) begin
							if (k < ks_q) begin
								if (j < ks_q - 1) begin
									win_q[k][j] <= win_q[k][(j + 1) % K_MAX];
								end else if (j == ks_q - 1) begin
									win_q[k][j] <= vec_q[k];
								end
							end
						end
					end
					if (ri_s >= half && c0 <= c1) begin
						state_q <= S_MSTART;
					end else begin
						state_q <= S_ADVANCE;
					end
				end
				S_MSTART: begin
					if (!out_vld_q) begin
						ky_q    <= '0;
						kx_q    <= '0;
						fl_q    <= '0;
						state_q <= S_MISSUE;
					end
				end
				S_MISSUE: begin
					mac_s1.vld     <= 1'b1;
					mac_s1.use_tap <= muse;
					mac_s1.first   <= (fl_q == '0);
					mac_s1.last    <= (PW'(ky_q) == ksz - 1) && (PW'(kx_q) == ksz - 1);
					fl_q <= fl_q + 1'b1;
					if (PW'(kx_q) == ksz - 1) begin
						kx_q <= '0;
						ky_q <= ky_q + 1'b1;
						if (PW'(ky_q) == ksz - 1) begin
							state_q <= S_MWAIT;
						end
					end else begin
						kx_q <= kx_q + 1'b1;
					end
				end
				S_MWAIT: begin
					if (res_vld) begin
						out_vld_q <= 1'b1;
						if (c_q == c1_q) begin
							state_q <= S_ADVANCE;
						end else begin
							state_q <= S_MSTART;
						end
					end
				end
				S_ADVANCE: begin
					if (ci_s + 1 >= w_eff) begin
						ci_q <= '0;
						if (ri_s + 1 >= h_eff + half) begin
							ri_q    <= '0;
							rslot_q <= '0;
						end else begin
							ri_q    <= ri_q + 1'b1;
							rslot_q <= (PW'(rslot_q) + 1 == ksz - 1) ? '0 : rslot_q + 1'b1;
						end
					end else begin
						ci_q <= ci_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q <= (mode == MODE_PIXEL) ? pixel_in : '0;
		end
		if (state_q == S_FETCH) begin
			fk_s1   <= kf_q;
			fsrc_s1 <= fsrc;
		end
		if (fvld_s1) begin
			case (fsrc_s1)
				SRC_MEM: vec_q[fk_s1] <= line_rd;
				SRC_PIX: vec_q[fk_s1] <= pix_q;
				default: vec_q[fk_s1] <= '0;
			endcase
		end
		tap_s1 <= win_q[ky_q][mj[JW-1:0]];
		if (state_q == S_COMMIT) begin
			c_q  <= c0;
			c1_q <= c1;
		end else if (state_q == S_MWAIT && res_vld) begin
			c_q <= PW'(c_q + 1);
		end
		if (state_q == S_STATUS && !out_vld_q) begin
			pix_out_q <= '0;
			row_out_q <= '0;
			col_out_q <= '0;
			last_q    <= 1'b1;
			stat_q    <= 1'b1;
		end else if (state_q == S_MWAIT && res_vld) begin
			pix_out_q <= res;
			row_out_q <= ROW_O_W'(ri_s - half);
			col_out_q <= COL_O_W'(c_q);
			last_q    <= (c_q == c1_q);
			stat_q    <= 1'b0;
		end
	end

	assign out_valid   = out_vld_q;
	assign pixel_out   = pix_out_q;
	assign out_row     = row_out_q;
	assign out_col     = col_out_q;
	assign last_of_run = last_q;
	assign status      = stat_q;

`include "line_buffered_2d_convolution_top_assert.svh"

	`LBC_ASSERT(a_res_into_empty, !res_vld || !out_vld_q, "result would overwrite output beat")
	`LBC_ASSERT(a_no_write_in_fetch, !line_we || !fvld_s1, "line store written during fetch")
	`LBC_ASSERT(a_mac_out_empty, !mac_s1.vld || !out_vld_q, "mac issue while output busy")
	`LBC_ASSERT_NEXT(a_status_done, state_q == S_STATUS && !out_vld_q,
		out_vld_q && status && state_q == S_IDLE, "status beat not produced")

endmodule

// ----- bench/line_buffered_2d_convolution_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_buffered_2d_convolution_top_tb
// Streams coefficient, pixel and drain beats through the line-buffered 2-D
// filter, under several frame sizes, kernel sizes and border modes. A
// behavioral filter in the bench computes every expected output pixel, and
// each output beat is checked field by field in order. Both sides idle at
// random, the receiver holds off once for a long stretch, and the sender
// waits for the block to empty before each group of register writes.
// ---------------------------------------------------------------------------
module line_buffered_2d_convolution_top_tb;
	import lbc_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int KM = K_MAX_DEF;
	localparam int SETTLE_CYCLES = 2 * KM + 3 + (KM * KM + 5) * (KM / 2 + 1) + 40;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [1:0] {OP_BEAT, OP_REG, OP_SYNC} op_kind_t;

	typedef struct {
		op_kind_t kind;
		logic [1:0] mode;
		logic [CIDX_W-1:0] cidx;
		logic signed [PIX_W-1:0] cval;
		logic signed [PIX_W-1:0] pix;
		logic [1:0] reg_idx;
		logic [CFG_W-1:0] reg_data;
	} op_t;

	typedef struct {
		logic signed [PIX_W-1:0] pix;
		logic [ROW_O_W-1:0] row;
		logic [COL_O_W-1:0] col;
		logic last;
		logic status;
	} filtered_px_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_COEF;
	logic [CIDX_W-1:0] coefficient_index = '0;
	logic signed [PIX_W-1:0] coefficient_value = '0;
	logic signed [PIX_W-1:0] pixel_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [PIX_W-1:0] pixel_out;
	logic [ROW_O_W-1:0] out_row;
	logic [COL_O_W-1:0] out_col;
	logic last_of_run;
	logic status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	line_buffered_2d_convolution_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .coefficient_index(coefficient_index),
		.coefficient_value(coefficient_value), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_out(pixel_out), .out_row(out_row), .out_col(out_col),
		.last_of_run(last_of_run), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	op_t pending_ops[$];
	filtered_px_t expected_px[$];
	op_t offered_beat;
	op_t offered_reg;

	// Filter state mirrored in the bench.
	logic signed [PIX_W-1:0] row_mem [0:KM-2][0:MAX_WIDTH_DEF-1];
	logic signed [PIX_W-1:0] kernel_coef [0:KM*KM-1];
	logic signed [PIX_W-1:0] window_px [0:KM-1][0:KM-1];
	int cur_row, cur_col;
	logic [CFG_W-1:0] reg_width, reg_height;
	logic [KS_W-1:0] reg_ksize;
	logic reg_border;

	int errors = 0;
	int n_beats = 0, n_results = 0, n_status = 0, n_regs = 0, n_built = 0;
	int cyc = 0, idle_cycles = 0, sync_count = 0;
	int hold_left = 0;
	bit held = 0;
	wire quiet = (cyc >= 4000) && (cyc < 9000);

	function automatic int frame_w();
		return (reg_width < 3) ? 3 : (reg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : reg_width;
	endfunction

	function automatic int frame_h();
		return (reg_height < 3) ? 3 : (reg_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : reg_height;
	endfunction

	function automatic int row_tap(int y, int col, int pix, int h, int half);
		if (y < 0 || y >= h) begin
			if (!reg_border) return 0;
			y = (y < 0) ? 0 : h - 1;
		end
		if (y == cur_row) return pix;
		return row_mem[y % (2 * half)][col];
	endfunction

	function automatic logic signed [PIX_W-1:0] filter_px(int c, int w, int k);
		int half, x, j;
		longint acc, q;
		half = k / 2;
		acc = 0;
		for (int ky = 0; ky < k; ky++) begin
			for (int kx = 0; kx < k; kx++) begin
				x = c + kx - half;
				if (x < 0 || x > w - 1) begin
					if (!reg_border) continue;
					x = (x < 0) ? 0 : w - 1;
				end
				j = k - 1 - (cur_col - x);
				if (j < 0 || j >= KM) continue;
				acc += longint'(kernel_coef[ky * k + kx]) * longint'(window_px[ky][j]);
			end
		end
		q = (acc + 16384) >>> 15;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[PIX_W-1:0];
	endfunction

	function automatic void filter_beat(op_t b);
		int w, h, k, half, pix, c0, c1;
		int tap[KM];
		bit live;
		filtered_px_t e;
		if (b.mode == MODE_COEF) begin
			if (b.cidx < KM * KM) kernel_coef[b.cidx] = b.cval;
			return;
		end
		if (b.mode == MODE_NONE) return;
		if (!(reg_ksize[0] && reg_ksize >= 3 && reg_ksize <= KM)) begin
			e = '{pix: '0, row: '0, col: '0, last: 1'b1, status: 1'b1};
			expected_px.push_back(e);
			return;
		end
		w = frame_w();
		h = frame_h();
		k = reg_ksize;
		half = k / 2;
		live = cur_row < h;
		if ((b.mode == MODE_PIXEL) != live) return;
		pix = live ? int'(b.pix) : 0;
		for (int i = 0; i < k; i++)
			tap[i] = row_tap(cur_row - 2 * half + i, cur_col, pix, h, half);
		if (live) row_mem[cur_row % (2 * half)][cur_col] = pix[PIX_W-1:0];
		for (int i = 0; i < k; i++) begin
			for (int j = 0; j < k - 1; j++) window_px[i][j] = window_px[i][j + 1];
			window_px[i][k - 1] = tap[i][PIX_W-1:0];
		end
		if (cur_row >= half) begin
			if (cur_col < w - 1) begin
				c0 = cur_col - half;
				c1 = (cur_col >= half) ? c0 : c0 - 1;
			end else begin
				c0 = (w - 1 - half < 0) ? 0 : w - 1 - half;
				c1 = w - 1;
			end
			for (int c = c0; c <= c1; c++) begin
				e.pix = filter_px(c, w, k);
				e.row = ROW_O_W'(cur_row - half);
				e.col = COL_O_W'(c);
				e.last = (c == c1);
				e.status = 1'b0;
				expected_px.push_back(e);
			end
		end
		cur_col++;
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= h + half) cur_row = 0;
		end
	endfunction

	function automatic void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			CFG_WIDTH: reg_width = data;
			CFG_HEIGHT: reg_height = data;
			CFG_KSIZE: reg_ksize = data[KS_W-1:0];
			CFG_BORDER: reg_border = data[0];
		endcase
		cur_row = 0;
		cur_col = 0;
	endfunction

	task automatic add_beat(logic [1:0] m, int ci, int cv, int px);
		op_t o;
		o = '{kind: OP_BEAT, mode: m, cidx: ci[CIDX_W-1:0], cval: cv[PIX_W-1:0],
			pix: px[PIX_W-1:0], reg_idx: CFG_WIDTH, reg_data: '0};
		pending_ops.push_back(o);
		n_built++;
	endtask

	task automatic add_reg(logic [1:0] idx, int data);
		op_t o;
		o = '{kind: OP_REG, mode: MODE_NONE, cidx: '0, cval: '0, pix: '0,
			reg_idx: idx, reg_data: data[CFG_W-1:0]};
		pending_ops.push_back(o);
	endtask

	task automatic add_sync();
		op_t o;
		o = '{kind: OP_SYNC, mode: MODE_NONE, cidx: '0, cval: '0, pix: '0,
			reg_idx: CFG_WIDTH, reg_data: '0};
		pending_ops.push_back(o);
	endtask

	task automatic add_setup(int w, int h, int k, int b);
		int cv;
		add_sync();
		add_reg(CFG_WIDTH, w);
		add_reg(CFG_HEIGHT, h);
		add_reg(CFG_KSIZE, k);
		add_reg(CFG_BORDER, b);
		for (int i = 0; i < k * k; i++) begin
			case ($urandom_range(2))
				0: cv = $urandom_range(8192) - 4096;
				1: cv = $urandom_range(65535) - 32768;
				default: cv = $urandom_range(1) ? 32767 : -32768;
			endcase
			add_beat(MODE_COEF, i, cv, $urandom);
		end
	endtask

	function automatic int rand_pix();
		case ($urandom_range(9))
			0: return 32767;
			1: return -32768;
			default: return $urandom_range(65535) - 32768;
		endcase
	endfunction

	task automatic add_frame(int w, int h, int k);
		for (int r = 0; r < h + k / 2; r++) begin
			for (int c = 0; c < w; c++) begin
				if ($urandom_range(19) == 0) begin
					case ($urandom_range(2))
						0: add_beat(MODE_NONE, $urandom, $urandom, $urandom);
						1: add_beat(r < h ? MODE_DRAIN : MODE_PIXEL, 0, 0, $urandom);
						default: add_beat(MODE_COEF, $urandom_range(63, 49), $urandom, 0);
					endcase
				end
				if (r < h) add_beat(MODE_PIXEL, 0, 0, rand_pix());
				else add_beat(MODE_DRAIN, 0, 0, $urandom);
			end
		end
	endtask

	// Sender: offers beats and register writes from the pending queue.
	always @(posedge clk or negedge arst_n) begin
		bit nv, ncv;
		op_t o;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				filter_beat(offered_beat);
				n_beats++;
			end
			if (cfg_valid && cfg_ready) begin
				write_reg(offered_reg.reg_idx, offered_reg.reg_data);
				n_regs++;
			end
			if (!(in_valid && !in_ready) && !(cfg_valid && !cfg_ready)) begin
				nv = 0;
				ncv = 0;
				if (pending_ops.size() > 0) begin
					case (pending_ops[0].kind)
						OP_SYNC: begin
							if (expected_px.size() == 0) begin
								if (sync_count >= SETTLE_CYCLES) begin
									void'(pending_ops.pop_front());
									sync_count = 0;
								end else begin
									sync_count++;
								end
							end
						end
						OP_REG: begin
							o = pending_ops.pop_front();
							offered_reg = o;
							cfg_index <= o.reg_idx;
							cfg_data <= o.reg_data;
							ncv = 1;
						end
						default: begin
							if (quiet || $urandom_range(99) >= 14) begin
								o = pending_ops.pop_front();
								offered_beat = o;
								mode <= o.mode;
								coefficient_index <= o.cidx;
								coefficient_value <= o.cval;
								pixel_in <= o.pix;
								nv = 1;
							end
						end
					endcase
				end
				in_valid <= nv;
				cfg_valid <= ncv;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!held && n_results >= 40) begin
			held <= 1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 14);
		end
	end

	// Checker and watchdog.
	always @(posedge clk) begin
		filtered_px_t e;
		if (arst_n) begin
			cyc++;
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("FAIL line_buffered_2d_convolution_top");
				$finish;
			end else if (out_valid && out_ready) begin
				n_results++;
				if (status) n_status++;
				if (expected_px.size() == 0) begin
					$display("%0t: unexpected beat pix=%0d row=%0d col=%0d", $time,
						pixel_out, out_row, out_col);
					errors++;
				end else begin
					e = expected_px.pop_front();
					if (pixel_out !== e.pix || out_row !== e.row || out_col !== e.col ||
						last_of_run !== e.last || status !== e.status) begin
						$display("%0t: mismatch expected pix=%0d row=%0d col=%0d last=%0b st=%0b",
							$time, e.pix, e.row, e.col, e.last, e.status);
						$display("%0t:          actual pix=%0d row=%0d col=%0d last=%0b st=%0b",
							$time, pixel_out, out_row, out_col, last_of_run, status);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int w, h, k;
		int ks[3];
		ks = '{3, 5, 7};
		for (int i = 0; i < KM * KM; i++) kernel_coef[i] = '0;
		for (int i = 0; i < KM; i++)
			for (int j = 0; j < KM; j++) window_px[i][j] = '0;
		for (int i = 0; i < KM - 1; i++)
			for (int j = 0; j < MAX_WIDTH_DEF; j++) row_mem[i][j] = '0;
		cur_row = 0;
		cur_col = 0;
		reg_width = 11'd1024;
		reg_height = 11'd1024;
		reg_ksize = 3'd3;
		reg_border = 1'b0;

		// Directed: extreme coefficients and pixels, ignored beats of each kind.
		add_sync();
		add_reg(CFG_WIDTH, 4);
		add_reg(CFG_HEIGHT, 3);
		add_reg(CFG_KSIZE, 3);
		add_reg(CFG_BORDER, 0);
		for (int i = 0; i < 9; i++)
			add_beat(MODE_COEF, i, (i % 2) ? 32767 : -32768, 0);
		add_beat(MODE_COEF, 63, 12345, 0);
		add_beat(MODE_COEF, 49, -1, 0);
		add_beat(MODE_PIXEL, 0, 0, 32767);
		add_beat(MODE_DRAIN, 0, 0, 0);
		add_beat(MODE_NONE, 63, -1, -1);
		for (int i = 1; i < 12; i++)
			add_beat(MODE_PIXEL, 0, 0, (i % 3 == 0) ? -32768 : (i % 3 == 1) ? -1 : 32767);
		add_beat(MODE_PIXEL, 0, 0, 5);
		for (int i = 0; i < 4; i++) add_beat(MODE_DRAIN, 0, 0, 0);
		// Invalid kernel sizes.
		add_sync();
		add_reg(CFG_KSIZE, 4);
		add_beat(MODE_PIXEL, 0, 0, 100);
		add_beat(MODE_DRAIN, 0, 0, 0);
		add_sync();
		add_reg(CFG_KSIZE, 1);
		add_beat(MODE_PIXEL, 0, 0, -100);
		// Largest register values, a partial frame only.
		add_setup(2047, 2047, 7, 1);
		for (int i = 0; i < 10; i++) add_beat(MODE_PIXEL, 0, 0, rand_pix());
		// Smallest sizes, clamped up to three.
		add_setup(0, 0, 3, 1);
		add_frame(3, 3, 3);

		while (n_built < 190) begin
			k = ks[$urandom_range(2)];
			w = $urandom_range(3, 9);
			h = $urandom_range(3, 5);
			add_setup(w, h, k, $urandom_range(1));
			add_frame(w, h, k);
			if ($urandom_range(2) == 0) add_frame(w, h, k);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_ops.size() == 0 && !in_valid && !cfg_valid && expected_px.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_px.size() != 0) begin
			$display("%0t: %0d expected pixels never arrived", $time, expected_px.size());
			errors++;
		end
		$display("Covered %0d input beats, %0d register writes, kernels 3/5/7 and invalid sizes.",
			n_beats, n_regs);
		$display("Checked %0d output pixels (%0d with error status), %0d mismatches.",
			n_results, n_status, errors);
		if (errors == 0)
			$display("PASS line_buffered_2d_convolution_top");
		else
			$display("FAIL line_buffered_2d_convolution_top");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lbc_pkg.sv
rtl/lbc_line_mem.sv
rtl/lbc_coef_mem.sv
rtl/lbc_mac.sv
rtl/line_buffered_2d_convolution_top.sv
bench/line_buffered_2d_convolution_top_tb.sv
